// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the curvature speed scheduler RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// plain property, sampled on the rising clock edge, off while in reset
`define CSPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("csps assertion failed");
// same-cycle implication
`define CSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("csps implication failed");
// next-cycle implication
`define CSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("csps next-cycle check failed");
`else
`define CSPS_ASSERT(lbl, clk, rstn, prop)
`define CSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/csps_pkg.sv =====
// Shared constants, codes and the CORDIC angle table for the speed scheduler.
// No dependencies.
package csps_pkg;

  localparam int PATH_DEPTH_DEF = 1024;

  // fixed-point constants, Q2.16 radians
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int CORDIC_STEPS = 16;

  // widths
  localparam int IN_DW   = 176;  // 170 payload bits, byte padded
  localparam int OUT_DW  = 40;   // 37 payload bits, byte padded
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 24;
  localparam int QW      = 34;   // atan2 operands
  localparam int CW_X    = 36;   // CORDIC x/y datapath
  localparam int ZW      = 20;   // CORDIC angle accumulator
  localparam int YAW_W   = 19;
  localparam int DIV_NW  = 40;   // dividend bits
  localparam int DIV_DW  = 33;   // divisor bits

  // register reset values
  localparam logic [19:0] MIN_SPEED_RST = 20'd6554;
  localparam logic [19:0] MAX_SPEED_RST = 20'd32768;
  localparam logic [23:0] MAX_CURV_RST  = 24'd196608;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MIN_SPEED = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_MAX_CURV  = 2'd2
  } cfg_idx_t;

  // atan(2^-i) in Q2.16
  function automatic logic signed [ZW-1:0] atan_tab(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/curvature_speed_scheduler.sv =====
// Curvature speed scheduler top level: control FSM, curvature memory, datapath.
// Depends on csps_pkg, csps_cordic, csps_sqrt, csps_div, assert_macros.svh.
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | pose load or speed query
//  out_    | out | tvalid/tready      | speed, normalized curvature, error
//  cfg_    | in  | we (no back-press) | min_speed, max_speed, max_curvature
//
// One transaction in flight. A pose load runs the CORDIC yaw steps, then,
// unless it is the first pose, the squaring, the square root steps and the
// divider steps (the divider is skipped for a zero distance). A query runs
// the divider, except when the peak is zero or the index is out of range;
// loads give no output transaction.
// Reset (rst_n low, synchronous) clears the path: no poses, peak zero.
// The curvature memory needs no clearing pass; only entries below the pose
// count are read. in_tready is high in the idle state, also while a result
// still sits in the output register; a stalled output only holds up the
// next query at its final step.
`include "assert_macros.svh"
module curvature_speed_scheduler import csps_pkg::*; #(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] quat_x,
  // [127:112] quat_y, [143:128] quat_z, [159:144] quat_w, [169:160] target_index
  input  logic [IN_DW-1:0]  in_tdata,
  // [0] kind, [1] first
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [19:0] speed, [36:20] norm_curvature
  output logic [OUT_DW-1:0] out_tdata,
  // [0] error
  output logic [0:0]        out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PREP  = 12'b0000_0000_0010,
    S_YAW   = 12'b0000_0000_0100,
    S_SQ    = 12'b0000_0000_1000,
    S_SQRT  = 12'b0000_0001_0000,
    S_DIV   = 12'b0000_0010_0000,
    S_STORE = 12'b0000_0100_0000,
    S_QA    = 12'b0000_1000_0000,
    S_QB    = 12'b0001_0000_0000,
    S_MUL   = 12'b0010_0000_0000,
    S_SPD   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t st_r, st_nxt;

  // config and path state
  logic [19:0]        min_r, max_r;
  logic [23:0]        maxc_r, peak_r;
  logic [CW-1:0]      pose_cnt_r;
  logic signed [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [YAW_W-1:0] prev_yaw_r;

  // curvature memory
  logic [23:0] mem [PATH_DEPTH];
  logic [23:0] rd_data_r;
  logic [AW-1:0] waddr, raddr;

  // captured transaction
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic [9:0]         idx_r;
  logic               first_r, query_r;

  // datapath
  logic signed [QW-1:0]    num_r, den_r;
  logic [30:0]             ax_r, ay_r, az_r, sq_sel;
  logic                    sh_r;
  logic signed [YAW_W-1:0] yaw_r;
  logic [17:0]             ad_r;
  logic [1:0]              sq_cnt_r;
  logic [61:0]             prod_r;
  logic [63:0]             acc_r;
  logic [23:0]             c_r;
  logic [DIV_NW-1:0]       div_num_r;
  logic [DIV_DW-1:0]       div_den_r;
  logic [16:0]             norm_r;
  logic signed [38:0]      sp_prod_r;
  logic [19:0]             res_speed_r, out_speed_r;
  logic [16:0]             res_norm_r, out_norm_r;
  logic                    res_err_r, out_err_r, out_valid_r;
  logic                    cordic_go_r, sqrt_go_r, div_go_r;

  // unit handshakes
  logic                    yaw_done, sqrt_done, div_done;
  logic signed [YAW_W-1:0] yaw;
  logic [31:0]             root;
  logic [DIV_NW-1:0]       quo;

  // combinational helpers
  logic              in_acc, in_first, out_free, div_start, idx_bad;
  logic [DIV_DW-1:0] dist_c;
  logic signed [QW-1:0] wz, xy, yy, zz, num_c, den_c;
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        adx, ady, adz;
  logic               sh_c;
  logic signed [ZW-1:0] dyaw, dwrap;
  logic signed [20:0] spd_diff;
  logic signed [22:0] adj;
  logic signed [23:0] spd;
  logic [31:0]        idx_ext;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_first  = in_tuser[1] || (pose_cnt_r == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign idx_ext   = {22'd0, idx_r};
  assign idx_bad   = idx_ext >= 32'(pose_cnt_r);
  assign raddr     = idx_ext[AW-1:0];
  assign waddr     = first_r ? '0 : pose_cnt_r[AW-1:0];
  assign dist_c    = sh_r ? {root, 1'b0} : {1'b0, root};

  // yaw operands: num = 2(wz+xy), den = 2^28 - 2(y^2+z^2)
  assign wz    = QW'(qw_r) * QW'(qz_r);
  assign xy    = QW'(qx_r) * QW'(qy_r);
  assign yy    = QW'(qy_r) * QW'(qy_r);
  assign zz    = QW'(qz_r) * QW'(qz_r);
  assign num_c = (wz + xy) <<< 1;
  assign den_c = QW'(268435456) - ((yy + zz) <<< 1);

  // position deltas; halve all when any reaches 2^31
  assign dx  = 33'(pos_x_r) - 33'(prev_x_r);
  assign dy  = 33'(pos_y_r) - 33'(prev_y_r);
  assign dz  = 33'(pos_z_r) - 33'(prev_z_r);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);
  assign sh_c = (adx[32:31] != 2'b00) || (ady[32:31] != 2'b00) || (adz[32:31] != 2'b00);

  // yaw change wrapped into +-pi
  assign dyaw  = ZW'(yaw) - ZW'(prev_yaw_r);
  assign dwrap = (dyaw > ZW'(PI_Q16))  ? dyaw - ZW'(2 * PI_Q16 + 1) :
                 (dyaw < -ZW'(PI_Q16)) ? dyaw + ZW'(2 * PI_Q16 + 1) : dyaw;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_sel = ax_r;
      2'd1:    sq_sel = ay_r;
      default: sq_sel = az_r;
    endcase
  end

  // speed = max - (max - min) * norm / 2^16, saturated
  assign spd_diff = $signed({1'b0, max_r}) - $signed({1'b0, min_r});
  assign adj      = 23'(sp_prod_r >>> 16);
  assign spd      = $signed({4'b0, max_r}) - 24'(adj);

  assign div_start = ((st_r == S_SQRT) && sqrt_done && (dist_c != '0)) ||
                     ((st_r == S_QB) && (peak_r != '0));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0])                                     st_nxt = S_QA;
          else if (!in_first && pose_cnt_r == CW'(PATH_DEPTH)) st_nxt = S_IDLE;
          else                                                 st_nxt = S_PREP;
        end
      end
      S_PREP:  st_nxt = S_YAW;
      S_YAW:   if (yaw_done) st_nxt = first_r ? S_STORE : S_SQ;
      S_SQ:    if (sq_cnt_r == 2'd3) st_nxt = S_SQRT;
      S_SQRT:  if (sqrt_done) st_nxt = (dist_c == '0) ? S_STORE : S_DIV;
      S_DIV:   if (div_done) st_nxt = query_r ? S_MUL : S_STORE;
      S_STORE: st_nxt = S_IDLE;
      S_QA:    st_nxt = idx_bad ? S_OUT : S_QB;
      S_QB:    st_nxt = (peak_r == '0) ? S_MUL : S_DIV;
      S_MUL:   st_nxt = S_SPD;
      S_SPD:   st_nxt = S_OUT;
      S_OUT:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // control and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      min_r       <= MIN_SPEED_RST;
      max_r       <= MAX_SPEED_RST;
      maxc_r      <= MAX_CURV_RST;
      pose_cnt_r  <= '0;
      peak_r      <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      prev_yaw_r  <= '0;
      cordic_go_r <= 1'b0;
      sqrt_go_r   <= 1'b0;
      div_go_r    <= 1'b0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cordic_go_r <= (st_r == S_PREP);
      sqrt_go_r   <= (st_r == S_SQ) && (sq_cnt_r == 2'd3);
      div_go_r    <= div_start;
      sq_cnt_r    <= (st_r == S_SQ) ? sq_cnt_r + 2'd1 : 2'd0;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MIN_SPEED: min_r  <= cfg_wdata[19:0];
          CFG_MAX_SPEED: max_r  <= cfg_wdata[19:0];
          CFG_MAX_CURV:  maxc_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (st_r == S_STORE) begin
        pose_cnt_r <= first_r ? CW'(1) : pose_cnt_r + CW'(1);
        peak_r     <= (first_r || c_r > peak_r) ? c_r : peak_r;
        prev_x_r   <= pos_x_r;
        prev_y_r   <= pos_y_r;
        prev_z_r   <= pos_z_r;
        prev_yaw_r <= yaw_r;
      end
      if ((st_r == S_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_tready)             out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_x_r <= in_tdata[31:0];
      pos_y_r <= in_tdata[63:32];
      pos_z_r <= in_tdata[95:64];
      qx_r    <= in_tdata[111:96];
      qy_r    <= in_tdata[127:112];
      qz_r    <= in_tdata[143:128];
      qw_r    <= in_tdata[159:144];
      idx_r   <= in_tdata[169:160];
      first_r <= in_first;
      query_r <= in_tuser[0];
    end
    if (st_r == S_PREP) begin
      num_r <= num_c;
      den_r <= den_c;
      sh_r  <= sh_c;
      ax_r  <= sh_c ? adx[31:1] : adx[30:0];
      ay_r  <= sh_c ? ady[31:1] : ady[30:0];
      az_r  <= sh_c ? adz[31:1] : adz[30:0];
      c_r   <= '0;
    end
    if ((st_r == S_YAW) && yaw_done) begin
      yaw_r <= yaw;
      ad_r  <= dwrap[ZW-1] ? 18'(-dwrap) : 18'(dwrap);
    end
    if (st_r == S_SQ) begin
      prod_r <= 62'(sq_sel) * 62'(sq_sel);
      acc_r  <= (sq_cnt_r == 2'd0) ? 64'd0 : acc_r + 64'(prod_r);
    end
    if ((st_r == S_SQRT) && sqrt_done) begin
      if (dist_c == '0) begin
        c_r <= (ad_r != '0) ? maxc_r : 24'd0;
      end else begin
        div_num_r <= DIV_NW'({ad_r, 16'd0});
        div_den_r <= dist_c;
      end
    end
    if ((st_r == S_DIV) && div_done) begin
      if (query_r) norm_r <= (quo > DIV_NW'(65536)) ? 17'd65536 : quo[16:0];
      else         c_r    <= (quo > DIV_NW'(maxc_r)) ? maxc_r : quo[23:0];
    end
    if ((st_r == S_QA) && idx_bad) begin
      res_speed_r <= '0;
      res_norm_r  <= '0;
      res_err_r   <= 1'b1;
    end
    if (st_r == S_QB) begin
      if (peak_r == '0) begin
        norm_r <= '0;
      end else begin
        div_num_r <= {rd_data_r, 16'd0};
        div_den_r <= DIV_DW'(peak_r);
      end
    end
    if (st_r == S_MUL) sp_prod_r <= 39'(spd_diff) * 39'($signed({1'b0, norm_r}));
    if (st_r == S_SPD) begin
      if (spd < 0)                      res_speed_r <= '0;
      else if (spd > 24'sd1048575)      res_speed_r <= 20'hFFFFF;
      else                              res_speed_r <= spd[19:0];
      res_norm_r <= norm_r;
      res_err_r  <= 1'b0;
    end
    if ((st_r == S_OUT) && out_free) begin
      out_speed_r <= res_speed_r;
      out_norm_r  <= res_norm_r;
      out_err_r   <= res_err_r;
    end
  end

  // curvature memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (st_r == S_STORE) mem[waddr] <= c_r;
    rd_data_r <= mem[raddr];
  end

  csps_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cordic_go_r),
    .num   (num_r),
    .den   (den_r),
    .done  (yaw_done),
    .yaw   (yaw)
  );

  csps_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sqrt_go_r),
    .n     (acc_r),
    .done  (sqrt_done),
    .root  (root)
  );

  csps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_norm_r, out_speed_r};
  assign out_tuser  = out_err_r;

  `CSPS_ASSERT(a_cnt_bound, clk, rst_n, 32'(pose_cnt_r) <= 32'(PATH_DEPTH))
  `CSPS_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  `CSPS_ASSERT_IMP(a_norm_max, clk, rst_n, out_tvalid, out_norm_r <= 17'd65536)
  `CSPS_ASSERT_NXT(a_peak_grows, clk, rst_n, st_r == S_STORE, peak_r >= $past(c_r))

endmodule

// ===== hdl/csps_cordic.sv =====
// Iterative vectoring CORDIC: yaw = atan2(num, den), one step per cycle.
// Depends on csps_pkg.
module csps_cordic import csps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [QW-1:0]    num,
  input  logic signed [QW-1:0]    den,
  output logic                    done,
  output logic signed [YAW_W-1:0] yaw
);

  logic signed [CW_X-1:0] x_r, y_r, xs, ys, x0, y0;
  logic signed [ZW-1:0]   z_r, z_step;
  logic [3:0]             it_r;
  logic                   busy_r, done_r;
  logic signed [YAW_W-1:0] yaw_r;

  assign x0 = CW_X'(den);
  assign y0 = CW_X'(num);
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign z_step = (y_r >= 0) ? z_r + atan_tab(it_r) : z_r - atan_tab(it_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        it_r <= '0;
        if (num == '0 && den == '0) begin
          yaw_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x0 < 0) begin
            // pre-rotate into the right half plane
            if (y0 >= 0) begin
              x_r <= y0;  y_r <= -x0;  z_r <= ZW'(HALF_PI_Q16);
            end else begin
              x_r <= -y0; y_r <= x0;   z_r <= -ZW'(HALF_PI_Q16);
            end
          end else begin
            x_r <= x0; y_r <= y0; z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r <= x_r + ys; y_r <= y_r - xs;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs;
        end
        z_r  <= z_step;
        it_r <= it_r + 4'd1;
        if (it_r == 4'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (z_step > ZW'(PI_Q16))       yaw_r <= YAW_W'(PI_Q16);
          else if (z_step < -ZW'(PI_Q16)) yaw_r <= -YAW_W'(PI_Q16);
          else                            yaw_r <= YAW_W'(z_step);
        end
      end
    end
  end

  assign done = done_r;
  assign yaw  = yaw_r;

endmodule

// ===== hdl/csps_sqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one root bit per cycle.
// Depends on csps_pkg.
module csps_sqrt import csps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  it_r;
  logic        busy_r, done_r;
  logic [35:0] r2, t2;

  assign r2 = {rem_r, n_r[63:62]};
  assign t2 = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        n_r    <= n;
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r <= {n_r[61:0], 2'b00};
        if (r2 >= t2) begin
          rem_r  <= 34'(r2 - t2);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= r2[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        it_r <= it_r + 5'd1;
        if (it_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hdl/csps_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on csps_pkg; shared by curvature and normalization.
module csps_div import csps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int ITW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [ITW-1:0]    it_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   r;

  assign r = {rem_r, q_r[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        q_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
        it_r   <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (r >= {1'b0, den_r}) begin
          rem_r <= DIV_DW'(r - {1'b0, den_r});
          q_r   <= {q_r[DIV_NW-2:0], 1'b1};
        end else begin
          rem_r <= r[DIV_DW-1:0];
          q_r   <= {q_r[DIV_NW-2:0], 1'b0};
        end
        it_r <= it_r + ITW'(1);
        if (it_r == ITW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
